// ----- src/bans_pkg.sv -----
// Shared constants, codes and types for the box-assisted neighbour search.
// Used by the top level and the serial divider; no dependencies.
`default_nettype none

package bans_pkg;

    localparam int MAX_VECTORS   = 1024;
    localparam int MAX_DIM       = 16;
    localparam int MAX_GRID_SIDE = 64;
    localparam int MAX_RESULTS   = 64;
    localparam int COORD_WIDTH   = 32;
    localparam int DIV_WIDTH     = COORD_WIDTH;

    localparam int NBINS     = MAX_GRID_SIDE * MAX_GRID_SIDE + 1;
    localparam int VIDX_W    = $clog2(MAX_VECTORS);
    localparam int CNT_W     = VIDX_W + 1;
    localparam int DIM_IDX_W = $clog2(MAX_DIM);
    localparam int DIM_W     = DIM_IDX_W + 1;
    localparam int RC_W      = $clog2(MAX_GRID_SIDE);
    localparam int SIDE_W    = RC_W + 1;
    localparam int WR_W      = SIDE_W + 1;
    localparam int BIN_W     = $clog2(NBINS);
    localparam int SADDR_W   = VIDX_W + DIM_IDX_W;
    localparam int RADIUS_W  = 31;
    localparam int WIN_W     = 11;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 31'd65536;
    localparam logic [CNT_W-1:0]    VCOUNT_RST = CNT_W'(MAX_VECTORS);
    localparam logic [4:0]          EDIM_RST   = 5'd2;
    localparam logic [6:0]          GSIDE_RST  = 7'd64;

    localparam logic [3:0] NO_SCAN   = 4'd9;
    localparam logic [3:0] LAST_STEP = 4'd8;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_CONT  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_VCOUNT = 2'd1,
        REG_EDIM   = 2'd2,
        REG_GSIDE  = 2'd3
    } t_reg;

    typedef enum logic [24:0] {
        S_IDLE    = 25'd1 << 0,
        S_CLEAR   = 25'd1 << 1,
        S_VLOOP   = 25'd1 << 2,
        S_BRD     = 25'd1 << 3,
        S_BLAT    = 25'd1 << 4,
        S_DIVA_GO = 25'd1 << 5,
        S_DIVA_W  = 25'd1 << 6,
        S_DIVB_GO = 25'd1 << 7,
        S_DIVB_W  = 25'd1 << 8,
        S_BINX    = 25'd1 << 9,
        S_BB_RD   = 25'd1 << 10,
        S_BB_WR   = 25'd1 << 11,
        S_PSUM_RD = 25'd1 << 12,
        S_PSUM_WR = 25'd1 << 13,
        S_STEP    = 25'd1 << 14,
        S_WRAP    = 25'd1 << 15,
        S_QB_RD   = 25'd1 << 16,
        S_QB_LAT  = 25'd1 << 17,
        S_SCAN    = 25'd1 << 18,
        S_CAND    = 25'd1 << 19,
        S_CHK     = 25'd1 << 20,
        S_CRD     = 25'd1 << 21,
        S_CCK     = 25'd1 << 22,
        S_HIT     = 25'd1 << 23,
        S_FINISH  = 25'd1 << 24
    } t_state;

    typedef enum logic [2:0] {
        PH_COUNT = 3'b001,
        PH_FILL  = 3'b010,
        PH_QUERY = 3'b100
    } t_phase;

endpackage

`default_nettype wire

// ----- src/bans_ram.sv -----
// Generic single-write, dual-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module bans_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]        o_rdata_a,
    input  wire [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]        o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

`default_nettype wire

// ----- src/bans_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bans_pkg for the default operand width.
`default_nettype none

module bans_div #(
    parameter int WIDTH = bans_pkg::DIV_WIDTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire [WIDTH-1:0]  i_num,
    input  wire [WIDTH-1:0]  i_den,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quo,
    output logic [WIDTH-1:0] o_rem
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_den;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   trial_sub;
    logic             ge;
    logic [WIDTH-1:0] n_rem;

    always_comb begin
        trial     = {r_rem, r_quo[WIDTH-1]};
        trial_sub = trial - {1'b0, r_den};
        ge        = (trial >= {1'b0, r_den});
        n_rem     = ge ? trial_sub[WIDTH-1:0] : trial[WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[WIDTH-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ----- src/box_assisted_neighbour_search.sv -----
// Box-assisted neighbour search: top level with APB register port and request channels.
// Depends on bans_pkg, bans_ram and bans_div.
// A load writes one coordinate. Binning one vector runs four serial divisions on one
// shared divider. A build clears the bin table (4097 entries), bins every
// vector twice (count and fill) and prefix-sums side*side+1 entries.
// A query bins the queried vector, then scans the bins around it and checks each
// candidate one coordinate pair at a time from the coordinate memory's two read ports.
// After reset the bin table is cleared before the first request is taken.
`default_nettype none

module box_assisted_neighbour_search #(
    parameter int MAX_RESULTS = bans_pkg::MAX_RESULTS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_command,
    input  wire  [9:0]  i_vector_index,
    input  wire  [3:0]  i_coordinate_index,
    input  wire  signed [31:0] i_coordinate_value,
    input  wire  signed [10:0] i_theiler_window,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [9:0]  o_neighbour_index,
    output logic        o_found,
    output logic        o_last,
    output logic        o_more_pending
);

    localparam int VIDX_W    = bans_pkg::VIDX_W;
    localparam int CNT_W     = bans_pkg::CNT_W;
    localparam int DIM_IDX_W = bans_pkg::DIM_IDX_W;
    localparam int DIM_W     = bans_pkg::DIM_W;
    localparam int RC_W      = bans_pkg::RC_W;
    localparam int SIDE_W    = bans_pkg::SIDE_W;
    localparam int WR_W      = bans_pkg::WR_W;
    localparam int BIN_W     = bans_pkg::BIN_W;
    localparam int SADDR_W   = bans_pkg::SADDR_W;
    localparam int RADIUS_W  = bans_pkg::RADIUS_W;
    localparam int CW        = bans_pkg::COORD_WIDTH;
    localparam int DVW       = bans_pkg::DIV_WIDTH;
    localparam int NRES_W    = $clog2(MAX_RESULTS + 1);

    // configuration
    logic [RADIUS_W-1:0] r_radius;
    logic [CNT_W-1:0]    r_vcount;
    logic [4:0]          r_edim;
    logic [6:0]          r_gside;

    logic [RADIUS_W-1:0] radius_e;
    logic [CNT_W-1:0]    cnt_e;
    logic [DIM_W-1:0]    dim_e;
    logic [SIDE_W-1:0]   side_e;
    logic [BIN_W-1:0]    nb_last;

    // control
    bans_pkg::t_state r_state;
    bans_pkg::t_phase r_phase;
    logic [CNT_W-1:0]    r_vec;
    logic [BIN_W-1:0]    r_bin;
    logic [CNT_W-1:0]    r_acc;
    logic [CW-1:0]       r_c0;
    logic [CW-1:0]       r_c1;
    logic                r_bsel;
    logic                r_neg;
    logic [RC_W-1:0]     r_row;
    logic [RC_W-1:0]     r_col;
    logic signed [WR_W-1:0] r_wr;
    logic [VIDX_W-1:0]   r_qv;
    logic [10:0]         r_qw;
    logic [RC_W-1:0]     r_qrow;
    logic [RC_W-1:0]     r_qcol;
    logic [3:0]          r_step;
    logic                r_setptr;
    logic [CNT_W-1:0]    r_ptr;
    logic [CNT_W-1:0]    r_lo;
    logic [VIDX_W-1:0]   r_cand;
    logic [DIM_W-1:0]    r_d;
    logic [NRES_W-1:0]   r_nres;
    logic                r_hold_v;
    logic [VIDX_W-1:0]   r_hold;
    logic                r_out_valid;
    logic [VIDX_W-1:0]   r_out_idx;
    logic                r_out_found;
    logic                r_out_last;
    logic                r_out_more;

    // memory ports
    logic               st_we;
    logic [SADDR_W-1:0] st_waddr, st_ra, st_rb;
    logic [CW-1:0]      st_wdata, st_rd_a, st_rd_b;
    logic               bb_we;
    logic [BIN_W-1:0]   bb_waddr, bb_ra, bb_rb;
    logic [CNT_W-1:0]   bb_wdata, bb_rd_a, bb_rd_b;
    logic               ml_we;
    logic [VIDX_W-1:0]  ml_waddr, ml_wdata, ml_ra, ml_rd;
    logic [VIDX_W-1:0]  ml_rd_b;

    // divider
    logic               div_start;
    logic [DVW-1:0]     div_num, div_den, div_quo, div_rem;
    logic               div_done;

    logic               in_acc;
    logic               cfg_wr;
    logic               out_free;
    logic [CW-1:0]      c_sel;
    logic [CW-1:0]      abs_c;
    logic [SIDE_W-1:0]  wrap_val;
    logic [BIN_W-1:0]   bin_calc;
    logic [CNT_W-1:0]   ptr_dec;
    logic [CNT_W-1:0]   pdec;
    logic [CNT_W-1:0]   psum;
    logic [1:0]         dr, dc;
    logic signed [WR_W-1:0] side_s;
    logic [VIDX_W-1:0]  idx_dist;
    logic               reject;
    logic [CW:0]        diff;
    logic [CW:0]        absd;
    logic               far;
    logic [DIM_IDX_W-1:0] dim_last;

    always_comb begin
        radius_e = (r_radius == '0) ? RADIUS_W'(1) : r_radius;
        if (r_vcount == '0) begin
            cnt_e = CNT_W'(1);
        end else if (r_vcount > CNT_W'(bans_pkg::MAX_VECTORS)) begin
            cnt_e = CNT_W'(bans_pkg::MAX_VECTORS);
        end else begin
            cnt_e = r_vcount;
        end
        if (r_edim == '0) begin
            dim_e = DIM_W'(1);
        end else if (r_edim > 5'(bans_pkg::MAX_DIM)) begin
            dim_e = DIM_W'(bans_pkg::MAX_DIM);
        end else begin
            dim_e = DIM_W'(r_edim);
        end
        if (r_gside == '0) begin
            side_e = SIDE_W'(1);
        end else if (r_gside > 7'(bans_pkg::MAX_GRID_SIDE)) begin
            side_e = SIDE_W'(bans_pkg::MAX_GRID_SIDE);
        end else begin
            side_e = SIDE_W'(r_gside);
        end
        nb_last  = BIN_W'(side_e) * BIN_W'(side_e);
        dim_last = DIM_IDX_W'(dim_e - 1'b1);
    end

    assign in_acc   = i_valid && o_ready;
    assign o_ready  = (r_state == bans_pkg::S_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        case (bans_pkg::t_reg'(paddr[3:2]))
            bans_pkg::REG_RADIUS: prdata = 32'(r_radius);
            bans_pkg::REG_VCOUNT: prdata = 32'(r_vcount);
            bans_pkg::REG_EDIM:   prdata = 32'(r_edim);
            bans_pkg::REG_GSIDE:  prdata = 32'(r_gside);
            default:              prdata = '0;
        endcase
    end

    // datapath helpers
    always_comb begin
        c_sel    = r_bsel ? r_c1 : r_c0;
        abs_c    = c_sel[CW-1] ? (~c_sel + 1'b1) : c_sel;
        wrap_val = (r_neg && div_rem[RC_W-1:0] != '0) ?
                   (side_e - SIDE_W'(div_rem[RC_W-1:0])) : SIDE_W'(div_rem[RC_W-1:0]);
        bin_calc = BIN_W'(side_e) * BIN_W'(r_row) + BIN_W'(r_col);
        ptr_dec  = r_ptr - 1'b1;
        pdec     = bb_rd_a - 1'b1;
        psum     = r_acc + bb_rd_a;
        side_s   = signed'(WR_W'(side_e));
        case (r_step)
            4'd0:    begin dr = 2'd0; dc = 2'd0; end
            4'd1:    begin dr = 2'd0; dc = 2'd1; end
            4'd2:    begin dr = 2'd0; dc = 2'd2; end
            4'd3:    begin dr = 2'd1; dc = 2'd0; end
            4'd4:    begin dr = 2'd1; dc = 2'd1; end
            4'd5:    begin dr = 2'd1; dc = 2'd2; end
            4'd6:    begin dr = 2'd2; dc = 2'd0; end
            4'd7:    begin dr = 2'd2; dc = 2'd1; end
            default: begin dr = 2'd2; dc = 2'd2; end
        endcase
        idx_dist = (r_qv >= r_cand) ? (r_qv - r_cand) : (r_cand - r_qv);
        reject   = (r_cand == r_qv) ||
                   (!r_qw[10] && {1'b0, idx_dist} <= r_qw);
        diff     = {st_rd_a[CW-1], st_rd_a} - {st_rd_b[CW-1], st_rd_b};
        absd     = diff[CW] ? (~diff + 1'b1) : diff;
        far      = (absd >= (CW+1)'(radius_e));
    end

    // memory addressing
    always_comb begin
        st_we    = in_acc && (bans_pkg::t_cmd'(i_command) == bans_pkg::CMD_LOAD);
        st_waddr = {i_vector_index, i_coordinate_index};
        st_wdata = i_coordinate_value;
        if (r_state == bans_pkg::S_CRD) begin
            st_ra = {r_qv, r_d[DIM_IDX_W-1:0]};
            st_rb = {r_cand, r_d[DIM_IDX_W-1:0]};
        end else begin
            st_ra = {r_vec[VIDX_W-1:0], DIM_IDX_W'(0)};
            st_rb = {r_vec[VIDX_W-1:0], dim_last};
        end

        bb_we    = 1'b0;
        bb_waddr = r_bin;
        bb_wdata = '0;
        bb_ra    = r_bin;
        bb_rb    = r_bin + 1'b1;
        case (r_state)
            bans_pkg::S_CLEAR: begin
                bb_we = 1'b1;
            end
            bans_pkg::S_BB_WR: begin
                bb_we    = 1'b1;
                bb_wdata = (r_phase == bans_pkg::PH_COUNT) ? (bb_rd_a + 1'b1) : pdec;
            end
            bans_pkg::S_PSUM_WR: begin
                bb_we    = 1'b1;
                bb_wdata = psum;
            end
            bans_pkg::S_QB_RD: begin
                bb_ra = bin_calc;
                bb_rb = bin_calc + 1'b1;
            end
            default: begin
            end
        endcase

        ml_we    = (r_state == bans_pkg::S_BB_WR) && (r_phase == bans_pkg::PH_FILL) &&
                   !pdec[CNT_W-1];
        ml_waddr = pdec[VIDX_W-1:0];
        ml_wdata = r_vec[VIDX_W-1:0];
        ml_ra    = ptr_dec[VIDX_W-1:0];

        div_start = (r_state == bans_pkg::S_DIVA_GO) || (r_state == bans_pkg::S_DIVB_GO);
        if (r_state == bans_pkg::S_DIVA_GO) begin
            div_num = DVW'(abs_c);
            div_den = DVW'(radius_e);
        end else begin
            div_num = div_quo;
            div_den = DVW'(side_e);
        end
    end

    bans_ram #(.WIDTH(CW), .DEPTH(bans_pkg::MAX_VECTORS * bans_pkg::MAX_DIM)) u_coord (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr_a(st_ra), .o_rdata_a(st_rd_a), .i_raddr_b(st_rb), .o_rdata_b(st_rd_b)
    );

    bans_ram #(.WIDTH(CNT_W), .DEPTH(bans_pkg::NBINS)) u_bounds (
        .i_clk(i_clk), .i_we(bb_we), .i_waddr(bb_waddr), .i_wdata(bb_wdata),
        .i_raddr_a(bb_ra), .o_rdata_a(bb_rd_a), .i_raddr_b(bb_rb), .o_rdata_b(bb_rd_b)
    );

    bans_ram #(.WIDTH(VIDX_W), .DEPTH(bans_pkg::MAX_VECTORS)) u_members (
        .i_clk(i_clk), .i_we(ml_we), .i_waddr(ml_waddr), .i_wdata(ml_wdata),
        .i_raddr_a(ml_ra), .o_rdata_a(ml_rd), .i_raddr_b(ml_ra), .o_rdata_b(ml_rd_b)
    );

    bans_div #(.WIDTH(DVW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den),
        .o_done(div_done), .o_quo(div_quo), .o_rem(div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= bans_pkg::RADIUS_RST;
            r_vcount    <= bans_pkg::VCOUNT_RST;
            r_edim      <= bans_pkg::EDIM_RST;
            r_gside     <= bans_pkg::GSIDE_RST;
            r_state     <= bans_pkg::S_CLEAR;
            r_phase     <= bans_pkg::PH_QUERY;
            r_vec       <= '0;
            r_bin       <= '0;
            r_acc       <= '0;
            r_bsel      <= 1'b0;
            r_neg       <= 1'b0;
            r_qv        <= '0;
            r_qw        <= '1;
            r_qrow      <= '0;
            r_qcol      <= '0;
            r_step      <= bans_pkg::NO_SCAN;
            r_setptr    <= 1'b0;
            r_ptr       <= '0;
            r_lo        <= '0;
            r_d         <= '0;
            r_nres      <= '0;
            r_hold_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (bans_pkg::t_reg'(paddr[3:2]))
                    bans_pkg::REG_RADIUS: r_radius <= pwdata[RADIUS_W-1:0];
                    bans_pkg::REG_VCOUNT: r_vcount <= pwdata[CNT_W-1:0];
                    bans_pkg::REG_EDIM:   r_edim   <= pwdata[4:0];
                    bans_pkg::REG_GSIDE:  r_gside  <= pwdata[6:0];
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                bans_pkg::S_IDLE: begin
                    if (in_acc) begin
                        case (bans_pkg::t_cmd'(i_command))
                            bans_pkg::CMD_BUILD: begin
                                r_phase <= bans_pkg::PH_COUNT;
                                r_bin   <= '0;
                                r_state <= bans_pkg::S_CLEAR;
                            end
                            bans_pkg::CMD_QUERY: begin
                                r_phase  <= bans_pkg::PH_QUERY;
                                r_qv     <= i_vector_index;
                                r_qw     <= i_theiler_window;
                                r_vec    <= CNT_W'(i_vector_index);
                                r_nres   <= '0;
                                r_hold_v <= 1'b0;
                                r_state  <= bans_pkg::S_BRD;
                            end
                            bans_pkg::CMD_CONT: begin
                                r_nres   <= '0;
                                r_hold_v <= 1'b0;
                                r_setptr <= 1'b0;
                                r_state  <= (r_step < bans_pkg::NO_SCAN) ?
                                            bans_pkg::S_STEP : bans_pkg::S_FINISH;
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                bans_pkg::S_CLEAR: begin
                    r_bin <= r_bin + 1'b1;
                    if (r_bin == BIN_W'(bans_pkg::NBINS - 1)) begin
                        r_vec   <= '0;
                        r_state <= (r_phase == bans_pkg::PH_COUNT) ?
                                   bans_pkg::S_VLOOP : bans_pkg::S_IDLE;
                    end
                end

                bans_pkg::S_VLOOP: begin
                    if (r_vec == cnt_e) begin
                        if (r_phase == bans_pkg::PH_COUNT) begin
                            r_bin   <= '0;
                            r_acc   <= '0;
                            r_state <= bans_pkg::S_PSUM_RD;
                        end else begin
                            r_state <= bans_pkg::S_IDLE;
                        end
                    end else begin
                        r_state <= bans_pkg::S_BRD;
                    end
                end

                bans_pkg::S_BRD: begin
                    r_state <= bans_pkg::S_BLAT;
                end

                bans_pkg::S_BLAT: begin
                    r_c0    <= st_rd_a;
                    r_c1    <= st_rd_b;
                    r_bsel  <= 1'b0;
                    r_state <= bans_pkg::S_DIVA_GO;
                end

                bans_pkg::S_DIVA_GO: begin
                    r_neg   <= c_sel[CW-1];
                    r_state <= bans_pkg::S_DIVA_W;
                end

                bans_pkg::S_DIVA_W: begin
                    if (div_done) begin
                        r_state <= bans_pkg::S_DIVB_GO;
                    end
                end

                bans_pkg::S_DIVB_GO: begin
                    r_state <= bans_pkg::S_DIVB_W;
                end

                bans_pkg::S_DIVB_W: begin
                    if (div_done) begin
                        if (!r_bsel) begin
                            r_row   <= wrap_val[RC_W-1:0];
                            r_bsel  <= 1'b1;
                            r_state <= bans_pkg::S_DIVA_GO;
                        end else begin
                            r_col   <= wrap_val[RC_W-1:0];
                            r_state <= bans_pkg::S_BINX;
                        end
                    end
                end

                bans_pkg::S_BINX: begin
                    r_bin <= bin_calc;
                    if (r_phase == bans_pkg::PH_QUERY) begin
                        r_qrow   <= r_row;
                        r_qcol   <= r_col;
                        r_step   <= '0;
                        r_setptr <= 1'b1;
                        r_state  <= bans_pkg::S_STEP;
                    end else begin
                        r_state <= bans_pkg::S_BB_RD;
                    end
                end

                bans_pkg::S_BB_RD: begin
                    r_state <= bans_pkg::S_BB_WR;
                end

                bans_pkg::S_BB_WR: begin
                    r_vec   <= r_vec + 1'b1;
                    r_state <= bans_pkg::S_VLOOP;
                end

                bans_pkg::S_PSUM_RD: begin
                    r_state <= bans_pkg::S_PSUM_WR;
                end

                bans_pkg::S_PSUM_WR: begin
                    r_acc <= psum;
                    if (r_bin == nb_last) begin
                        r_phase <= bans_pkg::PH_FILL;
                        r_vec   <= '0;
                        r_state <= bans_pkg::S_VLOOP;
                    end else begin
                        r_bin   <= r_bin + 1'b1;
                        r_state <= bans_pkg::S_PSUM_RD;
                    end
                end

                bans_pkg::S_STEP: begin
                    r_wr    <= signed'(WR_W'(r_qrow)) + signed'(WR_W'(dr)) - WR_W'(1);
                    r_bsel  <= 1'b0;
                    r_state <= bans_pkg::S_WRAP;
                end

                // fold the neighbor row, then column, back into the grid
                bans_pkg::S_WRAP: begin
                    if (r_wr < 0) begin
                        r_wr <= r_wr + side_s;
                    end else if (r_wr >= side_s) begin
                        r_wr <= r_wr - side_s;
                    end else if (!r_bsel) begin
                        r_row  <= r_wr[RC_W-1:0];
                        r_wr   <= signed'(WR_W'(r_qcol)) + signed'(WR_W'(dc)) - WR_W'(1);
                        r_bsel <= 1'b1;
                    end else begin
                        r_col   <= r_wr[RC_W-1:0];
                        r_state <= bans_pkg::S_QB_RD;
                    end
                end

                bans_pkg::S_QB_RD: begin
                    r_state <= bans_pkg::S_QB_LAT;
                end

                bans_pkg::S_QB_LAT: begin
                    r_lo <= bb_rd_a;
                    if (r_setptr) begin
                        r_ptr <= bb_rd_b;
                    end
                    r_setptr <= 1'b0;
                    r_state  <= bans_pkg::S_SCAN;
                end

                bans_pkg::S_SCAN: begin
                    if (r_ptr > r_lo) begin
                        r_ptr   <= ptr_dec;
                        r_state <= bans_pkg::S_CAND;
                    end else if (r_step == bans_pkg::LAST_STEP) begin
                        r_step  <= bans_pkg::NO_SCAN;
                        r_state <= bans_pkg::S_FINISH;
                    end else begin
                        r_step   <= r_step + 1'b1;
                        r_setptr <= 1'b1;
                        r_state  <= bans_pkg::S_STEP;
                    end
                end

                bans_pkg::S_CAND: begin
                    r_cand  <= ml_rd;
                    r_state <= bans_pkg::S_CHK;
                end

                bans_pkg::S_CHK: begin
                    r_d     <= '0;
                    r_state <= reject ? bans_pkg::S_SCAN : bans_pkg::S_CRD;
                end

                bans_pkg::S_CRD: begin
                    r_state <= bans_pkg::S_CCK;
                end

                bans_pkg::S_CCK: begin
                    if (far) begin
                        r_state <= bans_pkg::S_SCAN;
                    end else if (r_d + 1'b1 == dim_e) begin
                        r_state <= bans_pkg::S_HIT;
                    end else begin
                        r_d     <= r_d + 1'b1;
                        r_state <= bans_pkg::S_CRD;
                    end
                end

                // the held hit goes out once the next one (or the end) tells its flags
                bans_pkg::S_HIT: begin
                    if (out_free) begin
                        if (r_nres == NRES_W'(MAX_RESULTS)) begin
                            r_ptr       <= r_ptr + 1'b1;
                            r_out_valid <= 1'b1;
                            r_out_idx   <= r_hold;
                            r_out_found <= 1'b1;
                            r_out_last  <= 1'b1;
                            r_out_more  <= 1'b1;
                            r_state     <= bans_pkg::S_IDLE;
                        end else begin
                            if (r_hold_v) begin
                                r_out_valid <= 1'b1;
                                r_out_idx   <= r_hold;
                                r_out_found <= 1'b1;
                                r_out_last  <= 1'b0;
                                r_out_more  <= 1'b0;
                            end
                            r_hold   <= r_cand;
                            r_hold_v <= 1'b1;
                            r_nres   <= r_nres + 1'b1;
                            r_state  <= bans_pkg::S_SCAN;
                        end
                    end
                end

                bans_pkg::S_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_hold_v ? r_hold : '0;
                        r_out_found <= r_hold_v;
                        r_out_last  <= 1'b1;
                        r_out_more  <= 1'b0;
                        r_state     <= bans_pkg::S_IDLE;
                    end
                end

                default: begin
                    r_state <= bans_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = r_out_valid;
    assign o_neighbour_index = r_out_idx;
    assign o_found           = r_out_found;
    assign o_last            = r_out_last;
    assign o_more_pending    = r_out_more;

endmodule

`default_nettype wire
